[hdl/nvte_pkg.sv]
// Shared types and constants for the nearest valid table entry block.
// Holds table geometry, command codes and the transaction payload structs.
`default_nettype none

package nvte_pkg;

    // Table geometry
    localparam int NOTE_COUNT  = 88;
    localparam int LOWEST_NOTE = 21;
    localparam int LAYER_COUNT = 8;

    localparam int ROW_W  = $clog2(NOTE_COUNT);
    localparam int LAY_W  = 3;
    localparam int ROW_BITS = 8;

    // Command codes
    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_SET    = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [6:0] note;
        logic [3:0] layer;
    } t_in_item;

    typedef struct packed {
        logic       found;
        logic       exact_hit;
        logic [6:0] found_note;
        logic [2:0] found_layer;
    } t_out_item;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic             load;
        logic [ROW_W-1:0] row;
        logic [LAY_W-1:0] layer;
        logic             wr_en;
        logic             wr_set;
        logic [ROW_W-1:0] wr_row;
        logic [LAY_W-1:0] wr_layer;
    } t_cell_ctl;

endpackage

`default_nettype wire

[hdl/nearest_valid_table_entry.sv]
// Top level of the nearest valid entry finder: sequencer plus a chain of row cells.
// Depends on nvte_pkg and nvte_cell.
//
// Usage: the input channel (i_in_valid, o_in_stall, i_in_data) carries commands:
// lookup, mark entry valid, mark entry invalid. Every transaction yields exactly
// one result on the output channel (o_out_valid, i_out_stall, o_out_data).
// Writes and unused commands return an all-zero result in the cycle after acceptance.
// A lookup loads a pair of tokens into the cell of the clamped row; each cycle the
// low token moves one row down and the high token one row up, and the sequencer
// checks both at that note distance, low first. The note scan steps through every
// distance up to NOTE_COUNT - 1; a miss on the whole layer then leads to the layer
// search on the clamped row and then to posting the result. A hit ends the scan at
// its distance, so the layer search runs only when the whole layer misses.
// One lookup is in flight at a time; the next transaction is accepted once the
// sequencer is idle and the output register is free or being drained.
// Reset clears every valid bit at once, so a lookup right after reset finds nothing.
// A stalled result holds in the output register and the input stalls behind it.
`default_nettype none

module nearest_valid_table_entry
    import nvte_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_LAYER, S_DONE} t_state;

    t_state           r_state;
    logic [ROW_W-1:0] r_row;
    logic [LAY_W-1:0] r_lay;
    logic [ROW_W-1:0] r_dist;
    logic [ROW_BITS-1:0] r_row_bits;
    t_out_item        r_res;
    logic             r_out_valid;
    t_out_item        r_out_data;

    logic             in_acc;
    logic             out_free;
    logic [7:0]       note_off;
    logic             note_low;
    logic [ROW_W-1:0] n_row;
    logic [LAY_W-1:0] n_lay;
    logic             wr_ok;
    t_cell_ctl        cell_ctl;

    logic [NOTE_COUNT-1:0] tok_lo;
    logic [NOTE_COUNT-1:0] tok_hi;
    logic [NOTE_COUNT-1:0] hit_lo;
    logic [NOTE_COUNT-1:0] hit_hi;
    logic [ROW_BITS-1:0]   row_bits [NOTE_COUNT];
    logic [ROW_BITS-1:0]   row_bits_or;
    logic                  any_lo;
    logic                  any_hi;

    logic                  lay_found;
    logic [LAY_W-1:0]      lay_pick;

    function automatic logic [6:0] row_to_note(input logic [ROW_W-1:0] row);
        logic [7:0] sum;
        sum = 8'(row) + 8'(LOWEST_NOTE);
        return sum[6:0];
    endfunction

    // Handshake
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == S_IDLE) && out_free);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Clamp the request into the table and check write range
    always_comb begin
        note_off = {1'b0, i_in_data.note} - 8'(LOWEST_NOTE);
        note_low = ({1'b0, i_in_data.note} < 8'(LOWEST_NOTE));
        if (note_low) begin
            n_row = '0;
        end else if (note_off > 8'(NOTE_COUNT - 1)) begin
            n_row = ROW_W'(NOTE_COUNT - 1);
        end else begin
            n_row = note_off[ROW_W-1:0];
        end
        if (i_in_data.layer > 4'(LAYER_COUNT - 1)) begin
            n_lay = LAY_W'(LAYER_COUNT - 1);
        end else begin
            n_lay = i_in_data.layer[LAY_W-1:0];
        end
        wr_ok = !note_low && (note_off < 8'(NOTE_COUNT))
                && (i_in_data.layer < 4'(LAYER_COUNT));
    end

    // Broadcast control to the cells
    always_comb begin
        cell_ctl.load     = in_acc && (i_in_data.command == CMD_LOOKUP);
        cell_ctl.row      = n_row;
        cell_ctl.layer    = r_lay;
        cell_ctl.wr_en    = in_acc && wr_ok && ((i_in_data.command == CMD_SET)
                            || (i_in_data.command == CMD_CLEAR));
        cell_ctl.wr_set   = (i_in_data.command == CMD_SET);
        cell_ctl.wr_row   = note_off[ROW_W-1:0];
        cell_ctl.wr_layer = i_in_data.layer[LAY_W-1:0];
    end

    // Chain of row cells; low tokens move down, high tokens move up
    for (genvar i = 0; i < NOTE_COUNT; i++) begin : g_cell
        logic lo_in;
        logic hi_in;
        if (i == NOTE_COUNT - 1) begin : g_top_end
            assign lo_in = 1'b0;
        end else begin : g_lo_link
            assign lo_in = tok_lo[i+1];
        end
        if (i == 0) begin : g_bot_end
            assign hi_in = 1'b0;
        end else begin : g_hi_link
            assign hi_in = tok_hi[i-1];
        end
        nvte_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_index    (ROW_W'(i)),
            .i_ctl      (cell_ctl),
            .i_tok_lo   (lo_in),
            .i_tok_hi   (hi_in),
            .o_tok_lo   (tok_lo[i]),
            .o_tok_hi   (tok_hi[i]),
            .o_hit_lo   (hit_lo[i]),
            .o_hit_hi   (hit_hi[i]),
            .o_row_bits (row_bits[i])
        );
    end

    // Collect hits and the row under the token
    always_comb begin
        any_lo      = |hit_lo;
        any_hi      = |hit_hi;
        row_bits_or = '0;
        for (int i = 0; i < NOTE_COUNT; i++) begin
            row_bits_or = row_bits_or | row_bits[i];
        end
    end

    // Layer search on the clamped row, nearer first, lower before higher
    always_comb begin
        int lo;
        int hi;
        lay_found = 1'b0;
        lay_pick  = '0;
        for (int r = 1; r < LAYER_COUNT; r++) begin
            lo = int'(r_lay) - r;
            hi = int'(r_lay) + r;
            if (!lay_found && lo >= 0 && r_row_bits[LAY_W'(lo)]) begin
                lay_found = 1'b1;
                lay_pick  = LAY_W'(lo);
            end
            if (!lay_found && hi < LAYER_COUNT && r_row_bits[LAY_W'(hi)]) begin
                lay_found = 1'b1;
                lay_pick  = LAY_W'(hi);
            end
        end
    end

    // Sequencer state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in_data.command == CMD_LOOKUP) begin
                            r_row   <= n_row;
                            r_lay   <= n_lay;
                            r_dist  <= '0;
                            r_state <= S_SCAN;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_out_data  <= '0;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_dist == '0) begin
                        r_row_bits <= row_bits_or;
                    end
                    if (any_lo) begin
                        r_res.found       <= 1'b1;
                        r_res.exact_hit   <= (r_dist == '0);
                        r_res.found_note  <= row_to_note(r_row - r_dist);
                        r_res.found_layer <= r_lay;
                        r_state           <= S_DONE;
                    end else if (any_hi) begin
                        r_res.found       <= 1'b1;
                        r_res.exact_hit   <= 1'b0;
                        r_res.found_note  <= row_to_note(r_row + r_dist);
                        r_res.found_layer <= r_lay;
                        r_state           <= S_DONE;
                    end else if (r_dist == ROW_W'(NOTE_COUNT - 1)) begin
                        r_state <= S_LAYER;
                    end else begin
                        r_dist <= r_dist + 1'b1;
                    end
                end
                S_LAYER: begin
                    r_res.found       <= lay_found;
                    r_res.exact_hit   <= 1'b0;
                    r_res.found_note  <= lay_found ? row_to_note(r_row) : 7'd0;
                    r_res.found_layer <= lay_pick;
                    r_state           <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // At most one token of each direction is ever in the chain
    a_lo_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok_lo))
        else $error("more than one low token in chain");

    a_hi_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok_hi))
        else $error("more than one high token in chain");

    // The token sits on the requested row at distance zero
    a_tok_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_dist == '0) |-> (tok_lo != '0 && tok_lo == tok_hi))
        else $error("search token missing at distance zero");

    // A full note scan leaves both tokens past the chain ends
    a_scan_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LAYER) |-> (tok_lo == '0 && tok_hi == '0))
        else $error("tokens still in chain after full scan");

endmodule

`default_nettype wire

[hdl/nvte_cell.sv]
// One table row of the nearest valid entry chain: valid bits plus two search tokens.
// Depends on nvte_pkg; tokens move one row per cycle toward lower and higher notes.
`default_nettype none

module nvte_cell
    import nvte_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [ROW_W-1:0]    i_index,
    input  wire t_cell_ctl           i_ctl,
    input  wire logic                i_tok_lo,
    input  wire logic                i_tok_hi,
    output logic                     o_tok_lo,
    output logic                     o_tok_hi,
    output logic                     o_hit_lo,
    output logic                     o_hit_hi,
    output logic [ROW_BITS-1:0]      o_row_bits
);

    logic [ROW_BITS-1:0] r_valid;
    logic                r_tok_lo;
    logic                r_tok_hi;

    // Update valid bits on writes; load or shift the search tokens
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_tok_lo <= 1'b0;
            r_tok_hi <= 1'b0;
        end else begin
            if (i_ctl.wr_en && (i_ctl.wr_row == i_index)) begin
                r_valid[i_ctl.wr_layer] <= i_ctl.wr_set;
            end
            if (i_ctl.load) begin
                r_tok_lo <= (i_ctl.row == i_index);
                r_tok_hi <= (i_ctl.row == i_index);
            end else begin
                r_tok_lo <= i_tok_lo;
                r_tok_hi <= i_tok_hi;
            end
        end
    end

    // Report hits on the searched layer and expose the row under the low token
    assign o_tok_lo   = r_tok_lo;
    assign o_tok_hi   = r_tok_hi;
    assign o_hit_lo   = r_tok_lo & r_valid[i_ctl.layer];
    assign o_hit_hi   = r_tok_hi & r_valid[i_ctl.layer];
    assign o_row_bits = r_tok_lo ? r_valid : '0;

endmodule

`default_nettype wire

[tb/nvte_checker.sv]
// Checker for the nearest valid table entry block: watches both channels,
// predicts every result from its own copy of the valid map and compares.
// Depends on nvte_pkg for the payload structs, table geometry and command codes.

module nvte_checker
    import nvte_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_stall,
    input  wire t_in_item  i_in_data,
    input  wire logic      i_out_valid,
    input  wire logic      i_out_stall,
    input  wire t_out_item i_out_data,
    output int             o_fail_count,
    output int             o_pending,
    output int             o_results,
    output int             o_found
);

    // Predicted copy of the table: bit L of row i is note LOWEST_NOTE+i, layer L
    logic [ROW_BITS-1:0] entry_map [NOTE_COUNT];
    t_out_item           expected_results [$];
    int                  fails;
    int                  results_seen;
    int                  found_seen;

    initial begin
        fails        = 0;
        results_seen = 0;
        found_seen   = 0;
    end

    function automatic bit entry_is_valid(int row, int lay);
        if (row < 0 || row >= NOTE_COUNT || lay < 0 || lay >= LAYER_COUNT)
            return 1'b0;
        return entry_map[row][lay];
    endfunction

    // Apply one transaction to the map and return the result it should produce
    function automatic t_out_item nearest_entry(t_in_item req);
        t_out_item res;
        int        row;
        int        lay;
        int        hit_row;
        int        hit_lay;
        int        gap;
        bit        exact;
        res     = '0;
        hit_row = -1;
        hit_lay = -1;
        exact   = 1'b0;
        row     = int'(req.note) - LOWEST_NOTE;
        lay     = int'(req.layer);

        // Writes are not clamped; out-of-range writes are dropped
        if (req.command == CMD_SET || req.command == CMD_CLEAR) begin
            if (row >= 0 && row < NOTE_COUNT && lay < LAYER_COUNT)
                entry_map[row][lay] = (req.command == CMD_SET);
            return res;
        end
        if (req.command != CMD_LOOKUP)
            return res;

        // Clamp the request into the table
        if (row < 0)
            row = 0;
        if (row > NOTE_COUNT - 1)
            row = NOTE_COUNT - 1;
        if (lay > LAYER_COUNT - 1)
            lay = LAYER_COUNT - 1;

        if (entry_is_valid(row, lay)) begin
            exact   = 1'b1;
            hit_row = row;
        end
        // Same layer, growing note distance, lower note first
        for (gap = 1; hit_row < 0 && gap < NOTE_COUNT; gap++) begin
            if (entry_is_valid(row - gap, lay))
                hit_row = row - gap;
            else if (entry_is_valid(row + gap, lay))
                hit_row = row + gap;
        end
        if (hit_row >= 0)
            hit_lay = lay;
        // Same note, growing layer distance, lower layer first
        for (gap = 1; hit_row < 0 && gap < LAYER_COUNT; gap++) begin
            if (entry_is_valid(row, lay - gap)) begin
                hit_row = row;
                hit_lay = lay - gap;
            end else if (entry_is_valid(row, lay + gap)) begin
                hit_row = row;
                hit_lay = lay + gap;
            end
        end

        if (hit_row >= 0) begin
            res.found       = 1'b1;
            res.exact_hit   = exact;
            res.found_note  = 7'(hit_row + LOWEST_NOTE);
            res.found_layer = 3'(hit_lay);
        end
        return res;
    endfunction

    function automatic int field_mismatch(string name, int want, int got);
        if (want == got)
            return 0;
        $error("%s: expected %0d, actual %0d", name, want, got);
        return 1;
    endfunction

    // Sample both channels at the clock edge; results first, then new transactions
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            foreach (entry_map[r])
                entry_map[r] = '0;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                results_seen++;
                if (i_out_data.found)
                    found_seen++;
                if (expected_results.size() == 0) begin
                    $error("result with no transaction waiting: %p", i_out_data);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    fails += field_mismatch("found", want.found, i_out_data.found);
                    fails += field_mismatch("exact_hit", want.exact_hit,
                                            i_out_data.exact_hit);
                    fails += field_mismatch("found_note", want.found_note,
                                            i_out_data.found_note);
                    fails += field_mismatch("found_layer", want.found_layer,
                                            i_out_data.found_layer);
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(nearest_entry(i_in_data));
        end
        o_fail_count <= fails;
        o_pending    <= expected_results.size();
        o_results    <= results_seen;
        o_found      <= found_seen;
    end

endmodule

[tb/tb_top.sv]
// Top of the nearest valid table entry testbench: clock, reset, stimulus and verdict.
// Depends on nvte_pkg, the nearest_valid_table_entry block and nvte_checker.

module tb_top
    import nvte_pkg::*;
;

    // Command code the block does not use; must change nothing
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 880;
    localparam int IDLE_PCT     = 32;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = NOTE_COUNT + 12;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    int        fail_count;
    int        pending;
    int        results;
    int        found;
    int        sent_by_cmd [4];
    logic      steady;
    logic      hold_req;

    nearest_valid_table_entry u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    nvte_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results),
        .o_found      (found)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Hard stop if the block hangs
    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Drive the result stall: random idling, one long hold-off on request
    initial begin : out_stall_driver
        int  hold_left;
        bit  hold_done;
        hold_left   = 0;
        hold_done   = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (hold_req && !hold_done) begin
                i_out_stall <= 1'b1;
                hold_left = HOLD_CYCLES - 1;
                hold_done = 1'b1;
            end else begin
                i_out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    function automatic t_in_item make_item(logic [1:0] cmd, int note, int layer);
        t_in_item item;
        item.command = cmd;
        item.note    = 7'(note);
        item.layer   = 4'(layer);
        return item;
    endfunction

    // Fill the table sparsely first, then densely, then thin it out again
    function automatic t_in_item random_item(int idx);
        t_in_item item;
        int       pick;
        int       set_pct;
        int       clear_pct;
        set_pct   = (idx < 300) ? 20 : 40;
        clear_pct = (idx < 600) ? 10 : 35;
        pick      = $urandom_range(99);
        if (pick < 4)
            item.command = CMD_SPARE;
        else if (pick < 4 + set_pct)
            item.command = CMD_SET;
        else if (pick < 4 + set_pct + clear_pct)
            item.command = CMD_CLEAR;
        else
            item.command = CMD_LOOKUP;
        if ($urandom_range(99) < 75)
            item.note = 7'($urandom_range(LOWEST_NOTE, LOWEST_NOTE + NOTE_COUNT - 1));
        else
            item.note = 7'($urandom_range(0, 127));
        if ($urandom_range(99) < 80)
            item.layer = 4'($urandom_range(0, LAYER_COUNT - 1));
        else
            item.layer = 4'($urandom_range(0, 15));
        return item;
    endfunction

    // Offer one transaction after optional idle cycles; hold it until accepted
    task automatic send_item(input t_in_item item);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        sent_by_cmd[item.command]++;
    endtask

    initial begin : stimulus
        int idx;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        steady     = 1'b0;
        hold_req   = 1'b0;
        foreach (sent_by_cmd[c])
            sent_by_cmd[c] = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table, unused command, table corners and out-of-range writes
        send_item(make_item(CMD_LOOKUP, 60, 3));
        send_item(make_item(CMD_SPARE, 127, 15));
        send_item(make_item(CMD_SET, LOWEST_NOTE, 0));
        send_item(make_item(CMD_SET, LOWEST_NOTE + NOTE_COUNT - 1, LAYER_COUNT - 1));
        send_item(make_item(CMD_SET, LOWEST_NOTE - 1, 0));
        send_item(make_item(CMD_SET, LOWEST_NOTE + NOTE_COUNT, LAYER_COUNT - 1));
        send_item(make_item(CMD_SET, 50, LAYER_COUNT));
        // Clamped lookups below and above the table
        send_item(make_item(CMD_LOOKUP, 0, 0));
        send_item(make_item(CMD_LOOKUP, 127, 15));
        send_item(make_item(CMD_LOOKUP, LOWEST_NOTE + 1, 0));
        // Equal note distance on both sides: lower note wins
        send_item(make_item(CMD_SET, 60, 4));
        send_item(make_item(CMD_SET, 62, 4));
        send_item(make_item(CMD_LOOKUP, 61, 4));
        // Layer fallback: equal distance picks the lower layer, then a far layer
        send_item(make_item(CMD_SET, 61, 1));
        send_item(make_item(CMD_SET, 61, 3));
        send_item(make_item(CMD_LOOKUP, 61, 2));
        send_item(make_item(CMD_LOOKUP, 61, 6));
        // Clear a corner, then miss entirely; out-of-range clear is dropped
        send_item(make_item(CMD_CLEAR, LOWEST_NOTE, 0));
        send_item(make_item(CMD_LOOKUP, LOWEST_NOTE, 0));
        send_item(make_item(CMD_CLEAR, 5, 0));
        send_item(make_item(CMD_LOOKUP, 100, 7));
        send_item(make_item(CMD_LOOKUP, LOWEST_NOTE, 4));

        // Random traffic with a no-idle stretch and one long output hold-off
        for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
            steady <= (idx >= 150 && idx < 350);
            if (idx == 450)
                hold_req <= 1'b1;
            send_item(random_item(idx));
        end
        i_in_valid <= 1'b0;
        steady     <= 1'b0;

        // Drain, then give the block time to show any extra result
        do @(posedge i_clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d lookups, %0d sets, %0d clears and %0d unused commands;",
                 sent_by_cmd[CMD_LOOKUP], sent_by_cmd[CMD_SET],
                 sent_by_cmd[CMD_CLEAR], sent_by_cmd[CMD_SPARE]);
        $display("checked %0d results, %0d of them lookups that found an entry.",
                 results, found);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
hdl/nvte_pkg.sv
hdl/nvte_cell.sv
hdl/nearest_valid_table_entry.sv
tb/nvte_checker.sv
tb/tb_top.sv
